### hdl/alpha_premultiply_converter_top_defines.svh
// ----------------------------------------------------------------------------
// alpha premultiply converter assertion macros
// shared concurrent assertion forms, sampled on clk
// ----------------------------------------------------------------------------
`ifndef ALPHA_PREMULTIPLY_CONVERTER_TOP_DEFINES_SVH
`define ALPHA_PREMULTIPLY_CONVERTER_TOP_DEFINES_SVH

// same-cycle implication, off during reset
`define APC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define APC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, checked during reset too
`define APC_ASSERT_NEXT_RAW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/apc_pkg.sv
// ----------------------------------------------------------------------------
// apc_pkg
// types, codes and arithmetic helpers of the alpha premultiply converter
// ----------------------------------------------------------------------------
package apc_pkg;

  localparam int unsigned COMPONENTS = 4;
  localparam int unsigned NUM_COLORS = COMPONENTS - 1;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION  = 1'd1;

  localparam logic [1:0] MODE_NONE   = 2'd0;
  localparam logic [1:0] MODE_MASK   = 2'd1;
  localparam logic [1:0] MODE_ALPHA8 = 2'd2;

  localparam logic DIR_FWD = 1'b0;
  localparam logic DIR_BWD = 1'b1;

  localparam logic [7:0] FULL_ALPHA = 8'd255;

  typedef enum logic [2:0] {
    OP_PASS,
    OP_MASK_FWD,
    OP_MASK_BWD,
    OP_MUL,
    OP_DIV
  } op_t;

  typedef struct packed {
    logic [7:0] alpha_in;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] alpha_out;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
  } out_item_t;

  // work holds the color, the product or the running remainder and quotient
  typedef struct packed {
    logic        ovf;
    logic [15:0] work;
  } lane_t;

  typedef struct packed {
    op_t                        op;
    logic [7:0]                 alpha;
    lane_t [NUM_COLORS-1:0]     lane;
  } stg_t;

  // one restoring division step: remainder in the upper byte, quotient shifts in
  function automatic logic [15:0] div_step(logic [15:0] w, logic [7:0] a);
    logic [16:0] t;
    logic [8:0]  hi;
    t  = {w, 1'b0};
    hi = t[16:8];
    if (hi >= {1'b0, a}) begin
      hi   = hi - {1'b0, a};
      t[0] = 1'b1;
    end
    return {hi[7:0], t[7:0]};
  endfunction

endpackage

### hdl/apc_front.sv
// ----------------------------------------------------------------------------
// apc_front
// entry register with mode decode, then product or scaled dividend per color
// ----------------------------------------------------------------------------
module apc_front
  import apc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_item,
  input  logic [1:0] alpha_mode,
  input  logic       direction,
  output logic       dn_valid,
  output stg_t       dn_stg,
  input  logic       dn_ready
);

  logic s0_valid_r;
  stg_t s0_r;
  stg_t s0_nxt;
  logic s0_ready;
  logic s1_valid_r;
  stg_t s1_r;
  stg_t s1_nxt;
  logic s1_ready;
  op_t  op_dec;

  always_comb begin
    unique case (alpha_mode)
      MODE_ALPHA8: op_dec = (direction == DIR_BWD) ? OP_DIV : OP_MUL;
      MODE_MASK:   op_dec = (direction == DIR_BWD) ? OP_MASK_BWD : OP_MASK_FWD;
      default:     op_dec = OP_PASS;
    endcase
  end

  always_comb begin
    s0_nxt.op           = op_dec;
    s0_nxt.alpha        = in_item.alpha_in;
    s0_nxt.lane[2].ovf  = 1'b0;
    s0_nxt.lane[2].work = {8'd0, in_item.red_in};
    s0_nxt.lane[1].ovf  = 1'b0;
    s0_nxt.lane[1].work = {8'd0, in_item.green_in};
    s0_nxt.lane[0].ovf  = 1'b0;
    s0_nxt.lane[0].work = {8'd0, in_item.blue_in};
  end

  always_comb begin
    logic [7:0]  c;
    logic [15:0] n;
    s1_nxt = s0_r;
    for (int i = 0; i < NUM_COLORS; i++) begin
      c = s0_r.lane[i].work[7:0];
      n = {c, 8'd0} - {8'd0, c};
      case (s0_r.op)
        OP_MUL: begin
          s1_nxt.lane[i].work = 16'(c) * 16'(s0_r.alpha);
        end
        OP_DIV: begin
          s1_nxt.lane[i].work = n;
          s1_nxt.lane[i].ovf  = (n[15:8] >= s0_r.alpha);
        end
        default: begin
          s1_nxt.lane[i] = s0_r.lane[i];
        end
      endcase
    end
  end

  assign s1_ready = !s1_valid_r || dn_ready;
  assign s0_ready = !s0_valid_r || s1_ready;
  assign in_ready = s0_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      if (s0_ready) begin
        s0_valid_r <= in_valid;
      end
      if (s1_ready) begin
        s1_valid_r <= s0_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s0_ready && in_valid) begin
      s0_r <= s0_nxt;
    end
    if (s1_ready && s0_valid_r) begin
      s1_r <= s1_nxt;
    end
  end

  assign dn_valid = s1_valid_r;
  assign dn_stg   = s1_r;

endmodule

### hdl/apc_div_stage.sv
// ----------------------------------------------------------------------------
// apc_div_stage
// pipeline stage that runs two restoring division steps on each color of a divide item
// ----------------------------------------------------------------------------
module apc_div_stage
  import apc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic up_valid,
  output logic up_ready,
  input  stg_t up_stg,
  output logic dn_valid,
  output stg_t dn_stg,
  input  logic dn_ready
);

  logic valid_r;
  stg_t stg_r;
  stg_t stg_nxt;

  always_comb begin
    stg_nxt = up_stg;
    if (up_stg.op == OP_DIV) begin
      for (int i = 0; i < NUM_COLORS; i++) begin
        stg_nxt.lane[i].work =
          div_step(div_step(up_stg.lane[i].work, up_stg.alpha), up_stg.alpha);
      end
    end
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      stg_r <= stg_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_stg   = stg_r;

endmodule

### hdl/apc_back.sv
// ----------------------------------------------------------------------------
// apc_back
// last division steps, divide-by-255 rounding and result select into the
// output register
// ----------------------------------------------------------------------------
module apc_back
  import apc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      up_valid,
  output logic      up_ready,
  input  stg_t      up_stg,
  output logic      out_valid,
  output out_item_t out_item,
  input  logic      out_stall
);

  logic       valid_r;
  out_item_t  item_r;
  out_item_t  item_nxt;
  logic [7:0] col [NUM_COLORS];
  logic [7:0] alpha_res;

  always_comb begin
    logic [15:0] q;
    logic [24:0] t;
    for (int i = 0; i < NUM_COLORS; i++) begin
      q = div_step(div_step(up_stg.lane[i].work, up_stg.alpha), up_stg.alpha);
      t = {1'b0, up_stg.lane[i].work, 8'd0} + 25'(up_stg.lane[i].work)
          + 25'(FULL_ALPHA);
      case (up_stg.op)
        OP_MUL: begin
          col[i] = t[23:16];
        end
        OP_DIV: begin
          if (up_stg.alpha == 8'd0) begin
            col[i] = 8'd0;
          end else if (up_stg.lane[i].ovf) begin
            col[i] = FULL_ALPHA;
          end else begin
            col[i] = q[7:0];
          end
        end
        default: begin
          col[i] = up_stg.lane[i].work[7:0];
        end
      endcase
    end
  end

  always_comb begin
    case (up_stg.op)
      OP_MASK_FWD: alpha_res = up_stg.alpha[0] ? FULL_ALPHA : 8'd0;
      OP_MASK_BWD: alpha_res = {7'd0, (up_stg.alpha != 8'd0)};
      default:     alpha_res = up_stg.alpha;
    endcase
  end

  always_comb begin
    item_nxt.alpha_out = alpha_res;
    item_nxt.red_out   = col[2];
    item_nxt.green_out = col[1];
    item_nxt.blue_out  = col[0];
  end

  assign up_ready = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

### hdl/alpha_premultiply_converter_top.sv
// pipeline: six register stages from the entry register to the output register
// throughput: one item per cycle while out_stall is low; the eight quotient bits of the
// unpremultiply divide are spread two per stage over the last four stages
// in_stall rises only when every stage holds an item and out_stall is high
// reset (synchronous, rst_n low) empties the pipeline and sets alpha_mode and
// direction to zero
// ----------------------------------------------------------------------------
// alpha_premultiply_converter_top
// argb pixel converter between separate alpha and premultiplied alpha
// ----------------------------------------------------------------------------
`include "alpha_premultiply_converter_top_defines.svh"

module alpha_premultiply_converter_top
  import apc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [1:0] alpha_mode_r;
  logic       direction_r;
  logic       in_ready;
  logic       s1_valid;
  stg_t       s1_stg;
  logic       s1_ready;
  logic       s2_valid;
  stg_t       s2_stg;
  logic       s2_ready;
  logic       s3_valid;
  stg_t       s3_stg;
  logic       s3_ready;
  logic       s4_valid;
  stg_t       s4_stg;
  logic       s4_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_mode_r <= MODE_NONE;
      direction_r  <= DIR_FWD;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ALPHA_MODE: alpha_mode_r <= cfg_wdata[1:0];
        CFG_DIRECTION:  direction_r  <= cfg_wdata[0];
      endcase
    end
  end

  apc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .alpha_mode (alpha_mode_r),
    .direction  (direction_r),
    .dn_valid   (s1_valid),
    .dn_stg     (s1_stg),
    .dn_ready   (s1_ready)
  );

  apc_div_stage u_div_a (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_valid),
    .up_ready (s1_ready),
    .up_stg   (s1_stg),
    .dn_valid (s2_valid),
    .dn_stg   (s2_stg),
    .dn_ready (s2_ready)
  );

  apc_div_stage u_div_b (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s2_valid),
    .up_ready (s2_ready),
    .up_stg   (s2_stg),
    .dn_valid (s3_valid),
    .dn_stg   (s3_stg),
    .dn_ready (s3_ready)
  );

  apc_div_stage u_div_c (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s3_valid),
    .up_ready (s3_ready),
    .up_stg   (s3_stg),
    .dn_valid (s4_valid),
    .dn_stg   (s4_stg),
    .dn_ready (s4_ready)
  );

  apc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (s4_valid),
    .up_ready  (s4_ready),
    .up_stg    (s4_stg),
    .out_valid (out_valid),
    .out_item  (out_item),
    .out_stall (out_stall)
  );

  assign in_stall = !in_ready;

  `APC_ASSERT_NEXT_RAW(a_reset_empties, !rst_n, !out_valid, "output valid right after reset")
  `APC_ASSERT_IMPL(a_full_stalls, s4_valid && out_valid && out_stall, !s4_ready, "item moved into a stalled output")
  `APC_ASSERT_NEXT(a_mask_bit, s4_valid && s4_ready && s4_stg.op == OP_MASK_BWD, out_item.alpha_out[7:1] == 7'd0, "mask result wider than one bit")
  `APC_ASSERT_NEXT(a_div_zero, s4_valid && s4_ready && s4_stg.op == OP_DIV && s4_stg.alpha == 8'd0, out_item.red_out == 8'd0 && out_item.green_out == 8'd0 && out_item.blue_out == 8'd0, "zero alpha gave nonzero colors")

endmodule
